>>> src/dop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_pkg: shared types and constants for discharge overcurrent protection
// Level count, field widths, register indexes, alarm codes and the
// reciprocal used to turn milliamps into whole amps.
// ----------------------------------------------------------------------------
package dop_pkg;

   // Number of protection levels
   localparam int LEVELS = 3;

   // Item field widths
   localparam int LVL_W    = 2;
   localparam int MA_W     = 24;
   localparam int AMPS_W   = 14;
   localparam int KIND_W   = 2;
   localparam int STATES_W = 6;

   // Per-level register packing
   localparam int THR_W     = 16;
   localparam int DLY_W     = 8;
   localparam int THR_ALL_W = THR_W * LEVELS;
   localparam int DLY_ALL_W = DLY_W * LEVELS;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_DLY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_THR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_DLY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EV_EN   = 3'd4;

   // Divide by 1000: floor(x * DIV_MUL / 2^DIV_SHIFT) is exact for any
   // 24-bit magnitude (DIV_MUL * 1000 - 2^34 = 816 <= 2^(34-24))
   localparam int                DIV_MUL_W = 25;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = 25'd17179870;
   localparam int                DIV_SHIFT = 34;
   localparam int                PROD_W    = MA_W + DIV_MUL_W;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_SETTING   = 2'd1,
      ST_SET       = 2'd2,
      ST_RELEASING = 2'd3
   } alarm_state_type;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE    = 2'd0,
      EV_TRIP    = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   // Configuration registers as seen by the alarm logic
   typedef struct packed {
      logic [THR_ALL_W-1:0] set_thr;
      logic [DLY_ALL_W-1:0] set_dly;
      logic [THR_ALL_W-1:0] rel_thr;
      logic [DLY_ALL_W-1:0] rel_dly;
      logic                 ev_en;
   } cfg_type;

   // One check presented to the alarm logic
   typedef struct packed {
      logic              valid;
      logic [LVL_W-1:0]  level;
      logic [AMPS_W-1:0] amps;
   } step_type;

   // Outcome of one check
   typedef struct packed {
      event_kind_type      kind;
      logic [STATES_W-1:0] states;
   } alarm_out_type;

endpackage

>>> src/dop_amps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_amps: milliamp sample to qualified whole amps
// Takes the magnitude of the signed sample, divides by 1000 with a
// reciprocal multiply, and forces zero when the pack is not discharging.
// ----------------------------------------------------------------------------
module dop_amps (
   input  logic signed [dop_pkg::MA_W-1:0]   current_ma,
   input  logic                              discharging,
   output logic        [dop_pkg::AMPS_W-1:0] amps
);
   import dop_pkg::*;

   logic [MA_W-1:0]   mag;
   logic [PROD_W-1:0] prod;

   // Magnitude; the most negative sample maps to 2^23, still 24 bits
   assign mag = current_ma[MA_W-1] ? MA_W'(-current_ma) : MA_W'(current_ma);

   // Reciprocal multiply for the divide by 1000
   assign prod = PROD_W'(mag) * PROD_W'(DIV_MUL);

   // Drop the current when not discharging
   assign amps = discharging ? prod[DIV_SHIFT +: AMPS_W] : '0;

endmodule

>>> src/dop_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_alarm: per-level alarm states and delay counters
// Applies the trip rules, then the release rules, to the level named by
// the check, and reports the event and all level states after the update.
// ----------------------------------------------------------------------------
module dop_alarm (
   input  logic                   clock,
   input  logic                   reset,
   input  dop_pkg::step_type      step,
   input  dop_pkg::cfg_type       cfg,
   output dop_pkg::alarm_out_type result
);
   import dop_pkg::*;

   alarm_state_type            state_ff [LEVELS];
   alarm_state_type            state_in [LEVELS];
   logic [DLY_W-1:0]           trip_ff  [LEVELS];
   logic [DLY_W-1:0]           trip_in  [LEVELS];
   logic [DLY_W-1:0]           rel_ff   [LEVELS];
   logic [DLY_W-1:0]           rel_in   [LEVELS];
   event_kind_type             lane_kind [LEVELS];
   logic [LEVELS-1:0]          hit;
   logic [THR_W-1:0]           amps_ext;
   event_kind_type             kind;
   logic [STATES_W-1:0]        states;

   assign amps_ext = THR_W'(step.amps);

   // Next state of each level; only the addressed level moves
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         hit[i]       = step.valid && (step.level == LVL_W'(i));
         state_in[i]  = state_ff[i];
         trip_in[i]   = trip_ff[i];
         rel_in[i]    = rel_ff[i];
         lane_kind[i] = EV_NONE;
         if (hit[i]) begin
            // Trip rules
            if (amps_ext > cfg.set_thr[THR_W*i +: THR_W]) begin
               if (state_in[i] == ST_IDLE) begin
                  state_in[i] = ST_SETTING;
                  trip_in[i]  = DLY_W'(1);
               end else if (state_in[i] == ST_SETTING) begin
                  trip_in[i] = trip_in[i] + DLY_W'(1);
                  if (trip_in[i] >= cfg.set_dly[DLY_W*i +: DLY_W]) begin
                     lane_kind[i] = EV_TRIP;
                     state_in[i]  = ST_SET;
                     trip_in[i]   = '0;
                  end
               end
            end else if (state_in[i] == ST_SETTING) begin
               state_in[i] = ST_IDLE;
            end
            // Release rules, on what the trip rules left
            if (amps_ext < cfg.rel_thr[THR_W*i +: THR_W]) begin
               if (state_in[i] == ST_SET) begin
                  state_in[i] = ST_RELEASING;
                  rel_in[i]   = DLY_W'(1);
               end else if (state_in[i] == ST_RELEASING) begin
                  rel_in[i] = rel_in[i] + DLY_W'(1);
                  if (rel_in[i] >= cfg.rel_dly[DLY_W*i +: DLY_W]) begin
                     lane_kind[i] = EV_RELEASE;
                     state_in[i]  = ST_IDLE;
                     rel_in[i]    = '0;
                  end
               end
            end else if (state_in[i] == ST_RELEASING) begin
               state_in[i] = ST_SET;
            end
         end
      end
   end

   // Pick the event of the addressed level and pack all states
   always_comb begin
      kind   = EV_NONE;
      states = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (hit[i] && cfg.ev_en) begin
            kind = lane_kind[i];
         end
         if (2 * i + 1 < STATES_W) begin
            states[2*i +: 2] = state_in[i];
         end
      end
   end

   assign result.kind   = kind;
   assign result.states = states;

   // Hold alarm state and counters
   always_ff @(posedge clock) begin
      for (int i = 0; i < LEVELS; i++) begin
         if (reset) begin
            state_ff[i] <= ST_IDLE;
            trip_ff[i]  <= '0;
            rel_ff[i]   <= '0;
         end else begin
            state_ff[i] <= state_in[i];
            trip_ff[i]  <= trip_in[i];
            rel_ff[i]   <= rel_in[i];
         end
      end
   end

endmodule

>>> src/discharge_overcurrent_protect.sv
`timescale 1ns / 1ps
// An accepted item passes the input register, then the result register, to rsp_valid.
// Throughput: 1 item per cycle while results are not stalled; the alarm update is a
// combinational read-modify-write of the level state, so back-to-back checks chain.
// Reset: synchronous; all levels idle, counters zero, registers at their
// defaults (trip thresholds all ones, everything else zero).
// ----------------------------------------------------------------------------
// discharge_overcurrent_protect: overcurrent alarm with hysteresis and delay
// Input stage converts the sample to amps; the alarm stage updates the
// addressed level and loads the result register.
// ----------------------------------------------------------------------------
module discharge_overcurrent_protect (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration
   input  logic                                 csr_write,
   input  logic        [dop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [dop_pkg::CSR_DATA_W-1:0] csr_data,
   // Check items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [dop_pkg::LVL_W-1:0]      req_level,
   input  logic signed [dop_pkg::MA_W-1:0]       req_current_ma,
   input  logic                                 req_discharging,
   // Result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [dop_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic        [dop_pkg::LVL_W-1:0]      rsp_event_level,
   output logic        [dop_pkg::AMPS_W-1:0]     rsp_current_amps,
   output logic        [dop_pkg::STATES_W-1:0]   rsp_level_states
);
   import dop_pkg::*;

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [LVL_W-1:0]    in_level_ff;
   logic [AMPS_W-1:0]   in_amps_ff;
   logic [AMPS_W-1:0]   req_amps;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [LVL_W-1:0]    rsp_level_ff;
   logic [AMPS_W-1:0]   rsp_amps_ff;
   logic [STATES_W-1:0] rsp_states_ff;
   logic                advance;
   logic                req_take;
   step_type            step;
   alarm_out_type       alarm_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_thr <= '1;
         cfg_ff.set_dly <= '0;
         cfg_ff.rel_thr <= '0;
         cfg_ff.rel_dly <= '0;
         cfg_ff.ev_en   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SET_THR: cfg_ff.set_thr <= csr_data[THR_ALL_W-1:0];
            CSR_SET_DLY: cfg_ff.set_dly <= csr_data[DLY_ALL_W-1:0];
            CSR_REL_THR: cfg_ff.rel_thr <= csr_data[THR_ALL_W-1:0];
            CSR_REL_DLY: cfg_ff.rel_dly <= csr_data[DLY_ALL_W-1:0];
            CSR_EV_EN:   cfg_ff.ev_en   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the alarm stage advances when the result register frees
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Convert the sample on the way into the input register
   dop_amps u_amps (
      .current_ma  (req_current_ma),
      .discharging (req_discharging),
      .amps        (req_amps)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_level_ff <= req_level;
         in_amps_ff  <= req_amps;
      end
   end

   assign step.valid = in_valid_ff && advance;
   assign step.level = in_level_ff;
   assign step.amps  = in_amps_ff;

   dop_alarm u_alarm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg_ff),
      .result (alarm_out)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step.valid) begin
         rsp_kind_ff   <= alarm_out.kind;
         rsp_level_ff  <= in_level_ff;
         rsp_amps_ff   <= in_amps_ff;
         rsp_states_ff <= alarm_out.states;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_level  = rsp_level_ff;
   assign rsp_current_amps = rsp_amps_ff;
   assign rsp_level_states = rsp_states_ff;

`ifndef SYNTH
   logic [1:0] ev_state;
   assign ev_state = 2'(rsp_level_states >> {rsp_event_level, 1'b0});

   // No events are reported while reporting is off
   a_ev_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cfg_ff.ev_en |-> rsp_event_kind == EV_NONE)
      else $error("event reported while events are disabled");

   // A confirmed trip leaves its level set or already releasing
   a_trip_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_TRIP |->
         ev_state == ST_SET || ev_state == ST_RELEASING)
      else $error("trip event with level not set");

   // A confirmed release leaves its level idle
   a_rel_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_RELEASE |-> ev_state == ST_IDLE)
      else $error("release event with level not idle");

   // Stall only with an item waiting in the input register
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with room to advance");
`endif

endmodule

>>> tb/sv/discharge_overcurrent_protect_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discharge_overcurrent_protect_test: self-checking bench for the alarm block
// A directed table covers the field extremes, an out-of-range level, zero
// delays, hysteresis fallbacks, a trip and a move to releasing in one step
// and disabled events. Random phases then follow, each with its own register
// setting and handshake pressure. Typed rows are compared against hand-typed
// results, all others against a cycle-free model of the per-level alarm.
// ----------------------------------------------------------------------------
module discharge_overcurrent_protect_test;
   import dop_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int DIR_ROWS    = 32;

   typedef struct packed {
      event_kind_type        kind;
      logic [LVL_W-1:0]      level;
      logic [AMPS_W-1:0]     amps;
      logic [STATES_W-1:0]   states;
   } exp_rsp_type;

   typedef enum logic [1:0] {
      ROW_CHECK = 2'd0,
      ROW_TYPED = 2'd1,
      ROW_CSR   = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      logic [LVL_W-1:0]        level;
      logic signed [MA_W-1:0]  ma;
      logic                    dis;
      event_kind_type          exp_kind;
      logic [AMPS_W-1:0]       exp_amps;
      logic [STATES_W-1:0]     exp_states;
   } dir_row_type;

   // DUT ports
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [LVL_W-1:0]             req_level = '0;
   logic signed [MA_W-1:0]       req_current_ma = '0;
   logic                         req_discharging = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [KIND_W-1:0]            rsp_event_kind;
   logic [LVL_W-1:0]             rsp_event_level;
   logic [AMPS_W-1:0]            rsp_current_amps;
   logic [STATES_W-1:0]          rsp_level_states;

   // Hand-typed expectation travelling with the current item
   logic                         typed_on = 1'b0;
   exp_rsp_type                  typed_exp = '0;

   // Model copy of registers and per-level alarm state
   logic [THR_ALL_W-1:0]         set_thr_cfg = '1;
   logic [DLY_ALL_W-1:0]         set_dly_cfg = '0;
   logic [THR_ALL_W-1:0]         rel_thr_cfg = '0;
   logic [DLY_ALL_W-1:0]         rel_dly_cfg = '0;
   logic                         ev_en_cfg = 1'b0;
   alarm_state_type              alarm_st [LEVELS];
   logic [DLY_W-1:0]             trip_cnt [LEVELS];
   logic [DLY_W-1:0]             rel_cnt [LEVELS];

   exp_rsp_type                  pending_results [$];
   int                           mismatch_count = 0;
   int                           quiet_cycles = 0;
   int                           send_idle_pct = 0;
   int                           rsp_stall_pct = 0;

   dir_row_type dir_table [DIR_ROWS] = '{
      // reset defaults: nothing can trip, states stay idle
      '{ROW_TYPED, 3'd0, 48'h0, 2'd0, 24'sd0,       1'b1, EV_NONE, 14'd0,    6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd2, 24'sd8388607, 1'b1, EV_NONE, 14'd8388, 6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd1, 24'h800000,   1'b1, EV_NONE, 14'd8388, 6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd3, 24'h800000,   1'b1, EV_NONE, 14'd8388, 6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd0, 24'sd8388607, 1'b0, EV_NONE, 14'd0,    6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd1, -24'sd999,    1'b1, EV_NONE, 14'd0,    6'd0},
      '{ROW_TYPED, 3'd0, 48'h0, 2'd2, -24'sd1000,   1'b1, EV_NONE, 14'd1,    6'd0},
      // trip 10/50/100 A, release 5/20/200 A, level 1 delays 3 and 2
      '{ROW_CSR, CSR_SET_THR, 48'h0064_0032_000A, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CSR, CSR_SET_DLY, 48'h0000_0000_0300, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CSR, CSR_REL_THR, 48'h00C8_0014_0005, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CSR, CSR_REL_DLY, 48'h0000_0000_0200, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CSR, CSR_EV_EN,   48'h0000_0000_0001, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      // level 0, zero delays: setting, trip, releasing, release, fallback
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd11000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, -24'sd11000, 1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd3000,   1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd3000,   1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd11000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd8000,   1'b1, EV_NONE, 14'd0, 6'd0},
      // level 1: counted trip, releasing back to set, release via no discharge
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd60000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd60000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd60000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd10000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd25000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd60000,  1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd1, 24'sd0,      1'b1, EV_NONE, 14'd0, 6'd0},
      // level 2: release above trip, so a trip moves on to releasing
      '{ROW_CHECK, 3'd0, 48'h0, 2'd2, 24'sd150000, 1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd2, 24'sd150000, 1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd2, 24'sd150000, 1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd3, 24'sd150000, 1'b1, EV_NONE, 14'd0, 6'd0},
      // events off: the trip still happens but is not reported
      '{ROW_CSR, CSR_EV_EN,   48'h0000_0000_0000, 2'd0, 24'sd0, 1'b0, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd11000,  1'b1, EV_NONE, 14'd0, 6'd0},
      '{ROW_CHECK, 3'd0, 48'h0, 2'd0, 24'sd11000,  1'b1, EV_NONE, 14'd0, 6'd0}
   };

   discharge_overcurrent_protect dut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Random back-pressure on results
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Advance the alarm of one level by one check and return its result
   function automatic exp_rsp_type step_alarm(logic [LVL_W-1:0] lv, logic signed [MA_W-1:0] ma,
                                              logic dis);
      logic [MA_W:0]    mag;
      logic [AMPS_W-1:0] amps;
      alarm_state_type  st;
      event_kind_type   kind;
      logic [THR_W-1:0] sthr;
      logic [THR_W-1:0] rthr;
      logic [DLY_W-1:0] sdly;
      logic [DLY_W-1:0] rdly;
      exp_rsp_type      r;
      int               li;
      mag = ma[MA_W-1] ? (25'h1000000 - {1'b0, ma}) : {1'b0, ma};
      amps = dis ? AMPS_W'(mag / 1000) : '0;
      kind = EV_NONE;
      li = int'(lv);
      if (li < LEVELS) begin
         st = alarm_st[li];
         sthr = set_thr_cfg[THR_W*li +: THR_W];
         rthr = rel_thr_cfg[THR_W*li +: THR_W];
         sdly = set_dly_cfg[DLY_W*li +: DLY_W];
         rdly = rel_dly_cfg[DLY_W*li +: DLY_W];
         // trip side first
         if (amps > sthr) begin
            if (st == ST_IDLE) begin
               st = ST_SETTING;
               trip_cnt[li] = 8'd1;
            end else if (st == ST_SETTING) begin
               trip_cnt[li] = trip_cnt[li] + 8'd1;
               if (trip_cnt[li] >= sdly) begin
                  kind = EV_TRIP;
                  st = ST_SET;
                  trip_cnt[li] = 8'd0;
               end
            end
         end else if (st == ST_SETTING) begin
            st = ST_IDLE;
         end
         // then release side, on what the trip side left
         if (amps < rthr) begin
            if (st == ST_SET) begin
               st = ST_RELEASING;
               rel_cnt[li] = 8'd1;
            end else if (st == ST_RELEASING) begin
               rel_cnt[li] = rel_cnt[li] + 8'd1;
               if (rel_cnt[li] >= rdly) begin
                  kind = EV_RELEASE;
                  st = ST_IDLE;
                  rel_cnt[li] = 8'd0;
               end
            end
         end else if (st == ST_RELEASING) begin
            st = ST_SET;
         end
         alarm_st[li] = st;
      end
      if (!ev_en_cfg) kind = EV_NONE;
      r.kind = kind;
      r.level = lv;
      r.amps = amps;
      r.states = '0;
      for (int i = 0; i < LEVELS; i++) r.states[2*i +: 2] = alarm_st[i];
      return r;
   endfunction

   // Check results, record accepted items, watch for a hang
   always @(posedge clock) begin : monitor
      exp_rsp_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with none expected: kind %0d level %0d",
                                         rsp_event_kind, rsp_event_level));
            end else begin
               want = pending_results.pop_front();
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("event_kind got %0d expected %0d",
                                            rsp_event_kind, want.kind));
               if (rsp_event_level !== want.level)
                  report_mismatch($sformatf("event_level got %0d expected %0d",
                                            rsp_event_level, want.level));
               if (rsp_current_amps !== want.amps)
                  report_mismatch($sformatf("current_amps got %0d expected %0d",
                                            rsp_current_amps, want.amps));
               if (rsp_level_states !== want.states)
                  report_mismatch($sformatf("level_states got %h expected %h",
                                            rsp_level_states, want.states));
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            want = step_alarm(req_level, req_current_ma, req_discharging);
            if (typed_on) want = typed_exp;
            pending_results.push_back(want);
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[discharge_overcurrent_protect] ERROR");
            $finish;
         end
      end
   end

   // Present one check; entered and left at a falling edge
   task automatic send_check(logic [LVL_W-1:0] lv, logic signed [MA_W-1:0] ma, logic dis,
                             logic typed, exp_rsp_type typed_val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_level <= lv;
      req_current_ma <= ma;
      req_discharging <= dis;
      typed_on <= typed;
      typed_exp <= typed_val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain the block, then write one register and mirror it
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_SET_THR: set_thr_cfg = data[THR_ALL_W-1:0];
         CSR_SET_DLY: set_dly_cfg = data[DLY_ALL_W-1:0];
         CSR_REL_THR: rel_thr_cfg = data[THR_ALL_W-1:0];
         CSR_REL_DLY: rel_dly_cfg = data[DLY_ALL_W-1:0];
         CSR_EV_EN:   ev_en_cfg = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // One random phase: new register setting, new pressure, bursts of checks
   task automatic run_phase(int p);
      int                     flavor;
      int                     pressure;
      int                     count;
      int                     n;
      int                     pick;
      int                     lv_i;
      int                     dir;
      int                     dly;
      int                     blen;
      int                     lim;
      int                     amps;
      int                     mag;
      logic [THR_ALL_W-1:0]   sthr;
      logic [THR_ALL_W-1:0]   rthr;
      logic [DLY_ALL_W-1:0]   sdly;
      logic [DLY_ALL_W-1:0]   rdly;
      logic signed [MA_W-1:0] ma;
      exp_rsp_type            none;
      none = '0;
      flavor = p % 4;
      // pick the register setting
      for (int l = 0; l < LEVELS; l++) begin
         sthr[THR_W*l +: THR_W] = THR_W'($urandom_range(0, 40));
         rthr[THR_W*l +: THR_W] = THR_W'($urandom_range(0, 60));
         sdly[DLY_W*l +: DLY_W] = DLY_W'($urandom_range(0, 5));
         rdly[DLY_W*l +: DLY_W] = DLY_W'($urandom_range(0, 5));
      end
      case (flavor)
         1: begin
            sthr = '0;
            rthr = '1;
            sdly = '0;
            rdly = '0;
         end
         2: begin
            sdly = '1;
            rdly = '1;
         end
         3: begin
            sthr = THR_ALL_W'({$urandom, $urandom});
            rthr = THR_ALL_W'({$urandom, $urandom});
            sdly = DLY_ALL_W'($urandom);
            rdly = DLY_ALL_W'($urandom);
         end
         default: ;
      endcase
      write_reg(CSR_SET_THR, sthr);
      write_reg(CSR_SET_DLY, {24'($urandom), sdly});
      write_reg(CSR_REL_THR, rthr);
      write_reg(CSR_REL_DLY, {24'($urandom), rdly});
      write_reg(CSR_EV_EN, {47'({$urandom, $urandom}), 1'(p % 3 != 2)});
      // pick the handshake pressure
      pressure = (p / 2) % 4;
      send_idle_pct = (pressure == 1) ? 87 : (pressure == 3) ? 27 : 0;
      rsp_stall_pct = (pressure == 2) ? 87 : (pressure == 3) ? 27 : 0;
      count = (flavor == 2) ? 550 : 100;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95) begin
            // raw noise over the whole field range
            send_check(LVL_W'($urandom_range(0, 3)), MA_W'($urandom),
                       1'($urandom_range(0, 1)), 1'b0, none);
            n++;
         end else begin
            // burst at one level: above trip, below release, or a random current
            lv_i = (pick < 5) ? LEVELS : $urandom_range(0, LEVELS - 1);
            dir = $urandom_range(0, 2);
            dly = 3;
            if (lv_i < LEVELS)
               dly = (dir == 1) ? int'(rel_dly_cfg[DLY_W*lv_i +: DLY_W])
                                : int'(set_dly_cfg[DLY_W*lv_i +: DLY_W]);
            blen = $urandom_range(0, 1) ? dly + 2 : $urandom_range(1, dly + 3);
            for (int k = 0; k < blen && n < count; k++) begin
               amps = $urandom_range(0, 60);
               if (lv_i < LEVELS && dir == 0) begin
                  lim = int'(set_thr_cfg[THR_W*lv_i +: THR_W]);
                  amps = (lim >= 8388) ? 8388
                       : $urandom_range(lim + 1, (lim + 4 > 8388) ? 8388 : lim + 4);
               end else if (lv_i < LEVELS && dir == 1) begin
                  lim = int'(rel_thr_cfg[THR_W*lv_i +: THR_W]);
                  amps = (lim == 0) ? 0 : $urandom_range(0, (lim > 8389) ? 8388 : lim - 1);
               end
               mag = amps * 1000 + $urandom_range(0, 999);
               if (mag > 8388607) mag = 8388607;
               ma = MA_W'(mag);
               if ($urandom_range(0, 1)) ma = -ma;
               send_check(LVL_W'(lv_i), ma, ($urandom_range(0, 99) >= 8), 1'b0, none);
               n++;
            end
         end
      end
   endtask

   // Reset, directed table, random phases, drain and verdict
   initial begin : main
      dir_row_type row;
      exp_rsp_type tv;
      for (int i = 0; i < LEVELS; i++) begin
         alarm_st[i] = ST_IDLE;
         trip_cnt[i] = '0;
         rel_cnt[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (dir_table[i]) begin
         row = dir_table[i];
         if (row.kind == ROW_CSR) begin
            write_reg(row.idx, row.data);
         end else begin
            tv.kind = row.exp_kind;
            tv.level = row.level;
            tv.amps = row.exp_amps;
            tv.states = row.exp_states;
            send_check(row.level, row.ma, row.dis, row.kind == ROW_TYPED, tv);
         end
      end
      for (int p = 0; p < 10; p++) run_phase(p);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[discharge_overcurrent_protect] OK");
      end else begin
         $display("[discharge_overcurrent_protect] ERROR");
      end
      $finish;
   end

endmodule
